// ----- rtl/bmhpq_pkg.sv -----
// Shared types and constants for the binary max-heap priority queue.
// Depends on nothing; imported by the RAM wrapper users, sequencer, compare unit and top.
package bmhpq_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;

	// Widths derived from the capacity and the fixed port fields
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int CHILD_W = IDX_W + 2;
	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 6;
	localparam int OCC_W   = 7;
	localparam int STAT_W  = 2;
	localparam int CMP_W   = 32;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHANGE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD_POS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH_LAST,
		S_FETCH_OLD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_RESP
	} state_t;

	// Request from the sequencer to the heap store
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		value_t wdata;
		idx_t   raddr_a;
		idx_t   raddr_b;
	} mem_req_t;

	// Decisions of the shared compare unit
	typedef struct packed {
		logic key_gt_a;
		logic key_lt_a;
		logic take_left;
		logic take_right;
	} cmp_res_t;

endpackage

// ----- rtl/bmhpq_ram.sv -----
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module bmhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register both reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/bmhpq_cmp.sv -----
// Shared compare unit for sift-up, sift-down and change decisions.
// Depends on bmhpq_pkg.
module bmhpq_cmp (
	input  bmhpq_pkg::value_t   key,
	input  bmhpq_pkg::value_t   rd_a,
	input  bmhpq_pkg::value_t   rd_b,
	input  logic                l_ok,
	input  logic                r_ok,
	output bmhpq_pkg::cmp_res_t res
);
	import bmhpq_pkg::*;

	// rd_a is parent, old entry or left child; rd_b is the right child
	always_comb begin
		res.key_gt_a   = key > rd_a;
		res.key_lt_a   = key < rd_a;
		// Right child wins only when strictly above both the key and the left child
		res.take_right = r_ok && (rd_b > key) && (rd_b > rd_a);
		res.take_left  = l_ok && (rd_a > key) && !res.take_right;
	end

endmodule

// ----- rtl/bmhpq_seq.sv -----
// Sequencer: decodes a request and walks the heap one level at a time, a read state then a compare/write state.
// Depends on bmhpq_pkg and bmhpq_cmp; drives the heap store through mem_req_t.
module bmhpq_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bmhpq_pkg::OP_W-1:0]      opcode,
	input  logic [bmhpq_pkg::KEY_W-1:0]     key_value,
	input  logic [bmhpq_pkg::POS_W-1:0]     position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bmhpq_pkg::mem_req_t             mem_req,
	input  bmhpq_pkg::value_t               rd_a,
	input  bmhpq_pkg::value_t               rd_b,
	output bmhpq_pkg::value_t               removed,
	output logic [bmhpq_pkg::STAT_W-1:0]    status,
	output bmhpq_pkg::value_t               top,
	output bmhpq_pkg::cnt_t                 count
);
	import bmhpq_pkg::*;

	state_t   state_q, state_d;
	cnt_t     count_q, count_d;
	value_t   key_q, key_d;
	idx_t     idx_q, idx_d;
	value_t   removed_q, removed_d;
	status_t  status_q, status_d;
	value_t   top_q;
	value_t   in_val;
	cmp_res_t cmp;
	logic [CHILD_W-1:0] left_c, right_c;
	logic     l_ok, r_ok;
	idx_t     parent;

	assign in_val  = VALUE_WIDTH'(key_value);
	assign left_c  = CHILD_W'({idx_q, 1'b1});
	assign right_c = left_c + CHILD_W'(1);
	assign l_ok    = left_c < CHILD_W'(count_q);
	assign r_ok    = right_c < CHILD_W'(count_q);
	assign parent  = IDX_W'((idx_q - IDX_W'(1)) >> 1);

	bmhpq_cmp u_cmp (
		.key  (key_q),
		.rd_a (rd_a),
		.rd_b (rd_b),
		.l_ok (l_ok),
		.r_ok (r_ok),
		.res  (cmp)
	);

	// Next state, datapath updates and store accesses
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		key_d     = key_q;
		idx_d     = idx_q;
		removed_d = removed_q;
		status_d  = status_q;
		mem_req   = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				mem_req.raddr_a = IDX_W'(count_q - CNT_W'(1));
				if (op_t'(opcode) == OP_CHANGE) begin
					mem_req.raddr_a = IDX_W'(position);
				end
				if (in_valid) begin
					removed_d = '0;
					status_d  = ST_OK;
					state_d   = S_RESP;
					case (op_t'(opcode))
						OP_INSERT: begin
							if (count_q >= CNT_W'(CAPACITY)) begin
								status_d = ST_FULL;
							end else begin
								key_d   = in_val;
								idx_d   = IDX_W'(count_q);
								count_d = count_q + CNT_W'(1);
								state_d = S_UP_RD;
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								removed_d = top_q;
								count_d   = count_q - CNT_W'(1);
								if (count_q != CNT_W'(1)) begin
									state_d = S_FETCH_LAST;
								end
							end
						end
						OP_CHANGE: begin
							if (CMP_W'(position) >= CMP_W'(count_q)) begin
								status_d = ST_BAD_POS;
							end else begin
								key_d   = in_val;
								idx_d   = IDX_W'(position);
								state_d = S_FETCH_OLD;
							end
						end
						default: begin
							status_d = ST_BAD_POS;
						end
					endcase
				end
			end
			S_FETCH_LAST: begin
				// Last entry moves to the root
				key_d   = rd_a;
				idx_d   = '0;
				state_d = S_DN_RD;
			end
			S_FETCH_OLD: begin
				// Direction follows the old entry; equal value leaves the heap alone
				if (cmp.key_gt_a) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q;
					mem_req.wdata = key_q;
					state_d = S_UP_RD;
				end else if (cmp.key_lt_a) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q;
					mem_req.wdata = key_q;
					state_d = S_DN_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_UP_RD: begin
				mem_req.raddr_a = parent;
				if (idx_q == '0) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q;
					mem_req.wdata = key_q;
					state_d = S_RESP;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				if (cmp.key_gt_a) begin
					// Pull the parent down, move the hole up
					mem_req.wdata = rd_a;
					idx_d   = parent;
					state_d = S_UP_RD;
				end else begin
					mem_req.wdata = key_q;
					state_d = S_RESP;
				end
			end
			S_DN_RD: begin
				mem_req.raddr_a = IDX_W'(left_c);
				mem_req.raddr_b = IDX_W'(right_c);
				if (!l_ok) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q;
					mem_req.wdata = key_q;
					state_d = S_RESP;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q;
				if (cmp.take_right) begin
					mem_req.wdata = rd_b;
					idx_d   = IDX_W'(right_c);
					state_d = S_DN_RD;
				end else if (cmp.take_left) begin
					mem_req.wdata = rd_a;
					idx_d   = IDX_W'(left_c);
					state_d = S_DN_RD;
				end else begin
					mem_req.wdata = key_q;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Payload registers; shadow the root entry on every write to it
	always_ff @(posedge clk) begin
		key_q     <= key_d;
		idx_q     <= idx_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		if (mem_req.we && mem_req.waddr == '0) begin
			top_q <= mem_req.wdata;
		end
	end

	assign removed = removed_q;
	assign status  = status_q;
	assign top     = (count_q != '0) ? top_q : '0;
	assign count   = count_q;

endmodule

// ----- rtl/binary_max_heap_priority_queue_unit.sv -----
// Binary max-heap priority queue of CAPACITY entries: sequencer plus heap store.
// Depends on bmhpq_pkg, bmhpq_seq, bmhpq_cmp and bmhpq_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, key_value and position:
//   insert, remove top, or change the entry at a position. Output channel
//   (out_valid/out_ready) returns one transaction per request: removed_value,
//   top_value, occupancy and status (ok, empty, full, bad position).
//   The block handles one request at a time; in_ready is high only when idle.
//   A rejected request or a remove of the last entry goes straight to the
//   response; an equal change responds once the old entry is compared; a
//   sift walks the heap one level at a time, at most log2(CAPACITY) levels.
//   Each level costs one store read and one compare/write through the
//   shared compare unit. Once the result is taken the block returns to idle.
//   Reset empties the queue at once; the store itself is not cleared, since
//   only entries below the occupancy are ever read.
//   When the receiver stalls, the result holds on the outputs and no new
//   request is accepted until it is taken.
module binary_max_heap_priority_queue_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bmhpq_pkg::OP_W-1:0]       opcode,
	input  logic [bmhpq_pkg::KEY_W-1:0]      key_value,
	input  logic [bmhpq_pkg::POS_W-1:0]      position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bmhpq_pkg::KEY_W-1:0]      removed_value,
	output logic [bmhpq_pkg::KEY_W-1:0]      top_value,
	output logic [bmhpq_pkg::OCC_W-1:0]      occupancy,
	output logic [bmhpq_pkg::STAT_W-1:0]     status
);
	import bmhpq_pkg::*;

	mem_req_t mem_req;
	value_t   rd_a, rd_b;
	value_t   removed, top;
	cnt_t     count;

	bmhpq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.key_value (key_value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mem_req   (mem_req),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.removed   (removed),
		.status    (status),
		.top       (top),
		.count     (count)
	);

	bmhpq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.we      (mem_req.we),
		.waddr   (mem_req.waddr),
		.wdata   (mem_req.wdata),
		.raddr_a (mem_req.raddr_a),
		.raddr_b (mem_req.raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Widen or trim to the fixed port widths
	assign removed_value = KEY_W'(removed);
	assign top_value     = KEY_W'(top);
	assign occupancy     = OCC_W'(count);

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides active together");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
		else $error("full status while not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (count == '0 && removed == '0))
		else $error("empty status with entries or removed value");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op_t'(opcode) == OP_INSERT && count < CNT_W'(CAPACITY))
		|=> (count == $past(count) + CNT_W'(1)))
		else $error("insert did not grow occupancy");
`endif

endmodule
